### rtl/b64e_pkg.sv
// Package for the base64 stream encoder: word types, queue entry type,
// phase codes and the sextet-to-ASCII mapping. No dependencies.
`timescale 1ns / 1ps

package b64e_pkg;

  // Input word: one raw byte and its end-of-message flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Output word: one ASCII character
  typedef struct packed {
    logic [6:0] out_char;
    logic       end_of_message;
  } out_word_t;

  // Work for the back end: up to four characters for one input byte
  typedef struct packed {
    logic [3:0][6:0] chars;   // chars[0] goes out first
    logic [1:0]      cnt_m1;  // number of characters minus one
    logic            last;    // final character closes the message
  } b64e_job_t;

  // Position of the next byte inside its group of three
  localparam logic [1:0] PHASE_0 = 2'd0;
  localparam logic [1:0] PHASE_1 = 2'd1;
  localparam logic [1:0] PHASE_2 = 2'd2;

  localparam logic [6:0] PAD_CHAR = 7'h3D;  // '='

  localparam int B64E_QUEUE_DEPTH = 2;

  // Standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] v7;
    logic [6:0] ch;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      ch = v7 + 7'h41;             // 'A' + v
    end else if (v < 6'd52) begin
      ch = v7 + 7'h47;             // 'a' + (v - 26)
    end else if (v < 6'd62) begin
      ch = v7 - 7'h04;             // '0' + (v - 52)
    end else if (v == 6'd62) begin
      ch = 7'h2B;                  // '+'
    end else begin
      ch = 7'h2F;                  // '/'
    end
    return ch;
  endfunction

endpackage

### rtl/b64e_front.sv
// Front end of the base64 encoder: accepts bytes, tracks the group phase
// and leftover bits, and builds one job of characters per byte.
// Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_front
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      job_valid,
  input  logic      job_ready,
  output b64e_job_t job
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic       accept;
  logic [7:0] b;

  assign in_stall  = !job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;
  assign b         = in_word.data_byte;

  // Split the byte into characters according to the phase
  always_comb begin
    job       = '0;
    job.last  = in_word.last_byte;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    case (phase_r)
      PHASE_1: begin
        job.chars[0] = sextet_char({carry_r[1:0], b[7:4]});
        if (in_word.last_byte) begin
          job.chars[1] = sextet_char({b[3:0], 2'b00});
          job.chars[2] = PAD_CHAR;
          job.cnt_m1   = 2'd2;
        end else begin
          job.cnt_m1 = 2'd0;
          carry_nxt  = b[3:0];
          phase_nxt  = PHASE_2;
        end
      end
      PHASE_2: begin
        job.chars[0] = sextet_char({carry_r, b[7:6]});
        job.chars[1] = sextet_char(b[5:0]);
        job.cnt_m1   = 2'd1;
        carry_nxt    = 4'd0;
        phase_nxt    = PHASE_0;
      end
      default: begin
        job.chars[0] = sextet_char(b[7:2]);
        if (in_word.last_byte) begin
          job.chars[1] = sextet_char({b[1:0], 4'b0000});
          job.chars[2] = PAD_CHAR;
          job.chars[3] = PAD_CHAR;
          job.cnt_m1   = 2'd3;
        end else begin
          job.cnt_m1 = 2'd0;
          carry_nxt  = {2'b00, b[1:0]};
          phase_nxt  = PHASE_1;
        end
      end
    endcase
    // A message end restarts the group
    if (in_word.last_byte) begin
      phase_nxt = PHASE_0;
      carry_nxt = 4'd0;
    end
  end

  // Phase and leftover bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_0;
      carry_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

### rtl/b64e_queue.sv
// Short job queue between the encoder front and back ends.
// Register-based FIFO; depends on b64e_pkg for the job type.
`timescale 1ns / 1ps

module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = B64E_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  b64e_job_t push_job,
  output logic      pop_valid,
  input  logic      pop_req,
  output b64e_job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64e_job_t              entry_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_req && pop_valid;
  assign pop_job    = entry_r[rd_ptr_r];

  // Pointer and fill-level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/b64e_back.sv
// Back end of the base64 encoder: takes jobs from the queue and sends
// their characters one per cycle while out_stall is low, through a
// registered output word. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_back
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  b64e_job_t q_job,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      busy_r, busy_nxt;
  b64e_job_t job_r, job_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic      out_adv;
  logic      at_end;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_adv   = !out_valid_r || !out_stall;
  assign at_end    = (idx_r == job_r.cnt_m1);

  // Character sequencer
  always_comb begin
    busy_nxt      = busy_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    if (out_adv) begin
      out_valid_nxt = busy_r;
      out_word_nxt.out_char       = job_r.chars[idx_r];
      out_word_nxt.end_of_message = job_r.last && at_end;
      if (!busy_r || at_end) begin
        // load the next job, or go idle
        q_pop    = q_valid;
        busy_nxt = q_valid;
        job_nxt  = q_job;
        idx_nxt  = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_word_r <= out_word_nxt;
  end

`ifndef SYNTH
  // Character index stays within the loaded job
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= job_r.cnt_m1)
    else $error("b64e_back: index beyond job length");

  // A popped job starts at its first character
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> busy_r && idx_r == 2'd0)
    else $error("b64e_back: popped job not loaded");

  // Every message has at least four characters, so two ends never follow
  a_eom_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && out_word_r.end_of_message |=>
      !(out_valid_r && out_word_r.end_of_message))
    else $error("b64e_back: back-to-back end of message");
`endif

endmodule

### rtl/base64_stream_encoder.sv
// Top level of the streaming base64 encoder (standard alphabet, '=' pad).
// Instantiates b64e_front, b64e_queue and b64e_back; depends on b64e_pkg.
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall  in_word_t  (data_byte, last_byte)
//   out_     output     out_valid / out_stall out_word_t (out_char, end_of_message)
//
// The output sends one character per cycle while out_stall is low; a byte
// yields one, two, three or four characters (about 4/3 per byte over a long
// message), as the back end has a single character port.
// With the back end idle, an accepted byte is written into a queue entry,
// then into the back-end job register, then into the output register.
// Reset is synchronous, active low, and clears phase, queue and output valid.
// in_stall rises only when the job queue is full; out_stall holds the output.
`timescale 1ns / 1ps

module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = B64E_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      f_job_valid;
  logic      f_job_ready;
  b64e_job_t f_job;
  logic      q_valid;
  logic      q_pop;
  b64e_job_t q_job;

  // Byte intake and classification
  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .job_valid (f_job_valid),
    .job_ready (f_job_ready),
    .job       (f_job)
  );

  // Decoupling queue
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_job_valid),
    .push_ready (f_job_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_req    (q_pop),
    .pop_job    (q_job)
  );

  // Character output
  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_job     (q_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
